// ----- rtl/hpse_pkg.sv -----
// hazard pointer scan engine package
// command and result kind codes, config register indexes; no dependencies
package hpse_pkg;
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_SYNC  = 2'd1;
  localparam logic [1:0] CMD_SCAN  = 2'd2;

  localparam logic [2:0] KIND_DONE     = 3'd0;
  localparam logic [2:0] KIND_QUEUED   = 3'd1;
  localparam logic [2:0] KIND_REJECTED = 3'd2;
  localparam logic [2:0] KIND_COMPLETE = 3'd3;
  localparam logic [2:0] KIND_SCAN_END = 3'd4;

  localparam logic CFG_GROUP_SIZE = 1'b0;
  localparam logic CFG_SKIP       = 1'b1;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  tag;
    logic [63:0] group_mask;
    logic [4:0]  pending_count;
    logic        last;
  } result_t;
endpackage

// ----- rtl/hazard_pointer_scan_engine.sv -----
// hazard pointer scan engine top level: slot memory, waiter table, sequencer
// depends on hpse_pkg and hpse_group_div
//
// usage: in_ channel carries commands (write slot, synchronize, scan),
// out_ channel returns results, cfg_ writes group size (index 0) and
// skip mode (index 1).
// a slot write gives no result. a synchronize walks all NUM_CPUS slots,
// with a group division for each matching slot, then forms its one
// result; in skip mode it takes all groups without the walk. a scan steps
// past each free table entry and, for each valid waiter, does a select
// step, that walk and an update step, then gives one result per completed
// waiter plus a final scan-finished result. both walks use the shared group
// divider. one item is in work at a time; in_tready is low until all results
// of the item are taken.
// reset sets group size 1, clears skip mode and waiter valid bits, and clears
// the slot memory by a pass over all NUM_CPUS slots while no item is accepted.
// a stalled receiver holds the output register and stops the sequencer.
module hazard_pointer_scan_engine #(
  parameter int NUM_CPUS = 64,
  parameter int NUM_WAITERS = 16,
  parameter int GROUP_BITS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // command, cpu_index, pointer_value, request_tag
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // kind, tag, group_mask, pending_count
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data
);
  localparam int CW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int WW = (NUM_WAITERS > 1) ? $clog2(NUM_WAITERS) : 1;
  localparam logic [63:0] GMASK = (GROUP_BITS >= 64) ? '1 : ((64'(1) << GROUP_BITS) - 64'(1));

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_CHK   = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_SYNCF = 4'd5;
  localparam logic [3:0] S_WSEL  = 4'd6;
  localparam logic [3:0] S_WFIN  = 4'd7;
  localparam logic [3:0] S_SEND  = 4'd8;
  localparam logic [3:0] S_SCEND = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic [6:0] size_r;
  logic       skip_r;
  logic [63:0] slot_mem [NUM_CPUS];
  logic [63:0] slot_q;
  logic        we;
  logic [CW-1:0] waddr;
  logic [63:0] wdata;
  logic [CW:0] cpu_r, cpu_nxt;
  logic [1:0]  cmd_r;
  logic [63:0] ptr_r, ptr_nxt;
  logic [7:0]  rtag_r;
  logic        zm_r, zm_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [WW:0] wi_r, wi_nxt;
  logic [NUM_WAITERS-1:0] wvalid_r, wvalid_nxt;
  logic [63:0] wptr [NUM_WAITERS];
  logic [63:0] wmask [NUM_WAITERS];
  logic [7:0]  wtag [NUM_WAITERS];
  logic        wwr;
  logic [WW-1:0] wwa;
  logic [63:0] wmask_d;
  logic [NUM_WAITERS-1:0] done_r, done_nxt;
  hpse_pkg::result_t res_r, res_nxt;
  logic        ov_r, ov_nxt;
  logic        div_start, div_done;
  logic [63:0] gbit;
  logic [5:0]  cnt;
  logic [WW-1:0] wsel;
  logic [WW-1:0] free_idx;
  logic        free_any;
  logic [WW-1:0] done_idx;
  logic        done_any;

  hpse_group_div #(.CPU_W(CW), .GROUP_BITS(GROUP_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .cpu(cpu_r[CW-1:0]),
    .size(size_r), .done(div_done), .group_bit(gbit)
  );

  assign wsel = wi_r[WW-1:0];

  always_comb begin
    cnt = '0;
    free_any = 1'b0;
    free_idx = '0;
    done_any = 1'b0;
    done_idx = '0;
    for (int i = 0; i < NUM_WAITERS; i++) begin
      cnt = cnt + 6'(wvalid_r[i]);
    end
    for (int i = NUM_WAITERS - 1; i >= 0; i--) begin
      if (!wvalid_r[i]) begin
        free_any = 1'b1;
        free_idx = WW'(i);
      end
      if (done_r[i]) begin
        done_any = 1'b1;
        done_idx = WW'(i);
      end
    end
  end

  assign in_tready = (state_r == S_IDLE) && !ov_r;
  assign cfg_ready = 1'b1;
  assign out_tvalid = ov_r;
  assign out_tlast = res_r.last;
  assign out_tdata = {res_r.pending_count, res_r.group_mask, res_r.tag, res_r.kind};

  always_comb begin
    state_nxt = state_r;
    cpu_nxt = cpu_r;
    ptr_nxt = ptr_r;
    zm_nxt = zm_r;
    acc_nxt = acc_r;
    wi_nxt = wi_r;
    wvalid_nxt = wvalid_r;
    done_nxt = done_r;
    res_nxt = res_r;
    ov_nxt = ov_r;
    we = 1'b0;
    waddr = cpu_r[CW-1:0];
    wdata = '0;
    wwr = 1'b0;
    wwa = wsel;
    wmask_d = acc_r;
    div_start = 1'b0;
    if (ov_r && out_tready) ov_nxt = 1'b0;
    case (state_r)
      S_CLEAR: begin
        we = 1'b1;
        cpu_nxt = cpu_r + 1'b1;
        if (32'(cpu_r) == NUM_CPUS - 1) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        cpu_nxt = '0;
        acc_nxt = '0;
        wi_nxt = '0;
        done_nxt = '0;
        if (in_tvalid && in_tready) begin
          ptr_nxt = in_tdata[71:8];
          case (in_tdata[1:0])
            hpse_pkg::CMD_WRITE: begin
              if (32'(in_tdata[7:2]) < NUM_CPUS) begin
                we = 1'b1;
                waddr = CW'(in_tdata[7:2]);
                wdata = in_tdata[71:8];
              end
            end
            hpse_pkg::CMD_SYNC: begin
              if (skip_r) begin
                acc_nxt = GMASK;
                state_nxt = S_SYNCF;
              end else begin
                zm_nxt = 1'b1;
                state_nxt = S_RD;
              end
            end
            hpse_pkg::CMD_SCAN: begin
              state_nxt = S_WSEL;
            end
            default: ;
          endcase
        end
      end
      S_WSEL: begin
        if (32'(wi_r) >= NUM_WAITERS) begin
          state_nxt = S_SEND;
        end else if (wvalid_r[wsel]) begin
          ptr_nxt = wptr[wsel];
          zm_nxt = 1'b0;
          acc_nxt = '0;
          cpu_nxt = '0;
          state_nxt = S_RD;
        end else begin
          wi_nxt = wi_r + 1'b1;
        end
      end
      S_RD: state_nxt = S_CHK;
      S_CHK: begin
        if ((slot_q != 64'd0 || zm_r) && (slot_q == ptr_r || slot_q == '1)) begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end else begin
          cpu_nxt = cpu_r + 1'b1;
          if (32'(cpu_r) == NUM_CPUS - 1)
            state_nxt = (cmd_r == hpse_pkg::CMD_SYNC) ? S_SYNCF : S_WFIN;
          else state_nxt = S_RD;
        end
      end
      S_DIV: begin
        if (div_done) begin
          acc_nxt = acc_r | gbit;
          cpu_nxt = cpu_r + 1'b1;
          if (32'(cpu_r) == NUM_CPUS - 1)
            state_nxt = (cmd_r == hpse_pkg::CMD_SYNC) ? S_SYNCF : S_WFIN;
          else state_nxt = S_RD;
        end
      end
      S_WFIN: begin
        wwr = 1'b1;
        wmask_d = wmask[wsel] & acc_r;
        if (wmask_d == 64'd0) begin
          wvalid_nxt[wsel] = 1'b0;
          done_nxt[wsel] = 1'b1;
        end
        wi_nxt = wi_r + 1'b1;
        state_nxt = S_WSEL;
      end
      S_SYNCF: begin
        if (!ov_r) begin
          res_nxt.tag = rtag_r;
          res_nxt.last = 1'b1;
          if (acc_r == 64'd0) begin
            res_nxt.kind = hpse_pkg::KIND_DONE;
            res_nxt.group_mask = '0;
            res_nxt.pending_count = 5'(cnt);
          end else if (free_any) begin
            wwr = 1'b1;
            wwa = free_idx;
            wvalid_nxt[free_idx] = 1'b1;
            res_nxt.kind = hpse_pkg::KIND_QUEUED;
            res_nxt.group_mask = acc_r;
            res_nxt.pending_count = 5'(cnt + 6'd1);
          end else begin
            res_nxt.kind = hpse_pkg::KIND_REJECTED;
            res_nxt.group_mask = acc_r;
            res_nxt.pending_count = 5'(cnt);
          end
          ov_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_SEND: begin
        if (!ov_nxt) begin
          res_nxt.group_mask = '0;
          res_nxt.pending_count = 5'(cnt);
          ov_nxt = 1'b1;
          if (done_any) begin
            res_nxt.kind = hpse_pkg::KIND_COMPLETE;
            res_nxt.tag = wtag[done_idx];
            res_nxt.last = 1'b0;
            done_nxt[done_idx] = 1'b0;
          end else begin
            res_nxt.kind = hpse_pkg::KIND_SCAN_END;
            res_nxt.tag = '0;
            res_nxt.last = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) slot_mem[waddr] <= wdata;
    slot_q <= slot_mem[cpu_r[CW-1:0]];
    if (wwr) begin
      wmask[wwa] <= wmask_d;
      if (state_r == S_SYNCF) begin
        wptr[wwa] <= ptr_r;
        wtag[wwa] <= rtag_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      cpu_r <= '0;
      size_r <= 7'd1;
      skip_r <= 1'b0;
      wvalid_r <= '0;
      done_r <= '0;
      ov_r <= 1'b0;
      wi_r <= '0;
    end else begin
      state_r <= state_nxt;
      cpu_r <= cpu_nxt;
      wvalid_r <= wvalid_nxt;
      done_r <= done_nxt;
      ov_r <= ov_nxt;
      wi_r <= wi_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == hpse_pkg::CFG_GROUP_SIZE) size_r <= cfg_data;
        else skip_r <= cfg_data[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    zm_r <= zm_nxt;
    acc_r <= acc_nxt;
    res_r <= res_nxt;
    if (in_tvalid && in_tready) begin
      cmd_r <= in_tdata[1:0];
      rtag_r <= in_tdata[79:72];
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_tready |=> ov_r && $stable(res_r))
    else $error("result changed while stalled");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> state_r == S_IDLE && !ov_r)
    else $error("ready outside idle");
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    (done_r & wvalid_r) == '0)
    else $error("completed waiter still valid");
endmodule

// ----- rtl/hpse_group_div.sv -----
// cpu index to group bit: divides the cpu index by the group size
// by repeated subtraction, one step a cycle; uses hpse_pkg-free plain logic
module hpse_group_div #(
  parameter int CPU_W = 6,
  parameter int GROUP_BITS = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [CPU_W-1:0] cpu,
  input  logic [6:0]       size,
  output logic             done,
  output logic [63:0]      group_bit
);
  localparam int QW = (CPU_W + 1 > 7) ? CPU_W + 1 : 7;
  logic [QW-1:0] rem_r, rem_nxt;
  logic [QW-1:0] quo_r, quo_nxt;
  logic          busy_r, busy_nxt;
  logic [QW-1:0] sz;
  logic [QW:0]   szx;
  logic [QW-1:0] grp;

  assign szx = (size == 7'd0) ? (QW+1)'(1) : (QW+1)'(size);
  assign sz = szx[QW-1:0];

  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    busy_nxt = busy_r;
    done = 1'b0;
    if (start) begin
      rem_nxt = QW'(cpu);
      quo_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if ((QW+1)'(rem_r) >= szx) begin
        rem_nxt = rem_r - sz;
        quo_nxt = quo_r + QW'(1);
      end else begin
        busy_nxt = 1'b0;
        done = 1'b1;
      end
    end
  end

  assign grp = (32'(quo_r) >= GROUP_BITS) ? QW'(GROUP_BITS - 1) : quo_r;
  assign group_bit = 64'(1) << grp[5:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end
endmodule
